@@ rtl/hex_position_packet_decoder_unit_macros.svh @@
// Assertion macros shared by the decoder RTL.
// Needs signals named clk and rst in the scope where a macro is used.
`ifndef HEX_POSITION_PACKET_DECODER_UNIT_MACROS_SVH
`define HEX_POSITION_PACKET_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define HPPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define HPPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/hppd_pkg.sv @@
// Package for the hex position packet decoder: constants, types, character helpers.
// No dependencies.
package hppd_pkg;

  localparam int COORD_DIGITS = 3;          // hex digits per coordinate, 1 to 3
  localparam int HEADER_BYTES = 4;
  localparam int N_SLOTS      = 8;
  localparam int SLOT_W       = 3;
  localparam int COORD_W      = 12;
  localparam int BYTE_W       = 8;
  localparam int ENT_W        = 3;
  localparam int N_ENT        = 6;
  localparam int POS_W        = 6;
  localparam int POS_MAX      = 63;
  localparam int DIGIT_W      = 2;
  localparam int STEP_W       = 2;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = 1;
  localparam int QCNT_W       = 2;
  localparam int P_END        = HEADER_BYTES + 8 * COORD_DIGITS;
  localparam int A_END        = HEADER_BYTES + 4 * COORD_DIGITS;

  localparam logic [BYTE_W-1:0] CHAR_P = 8'h50;
  localparam logic [BYTE_W-1:0] CHAR_A = 8'h41;

  localparam logic [ENT_W-1:0] ENT_BALL  = 3'd0;
  localparam logic [ENT_W-1:0] ENT_CAR3  = 3'd3;
  localparam logic [ENT_W-1:0] ENT_START = 3'd4;
  localparam logic [ENT_W-1:0] ENT_GOAL  = 3'd5;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_P    = 2'd1,
    KIND_A    = 2'd2
  } kind_t;

  typedef logic [COORD_W-1:0] coord_t;

  // One checked packet, handed from the parser to the update sequencer
  typedef struct packed {
    logic                      is_a;
    coord_t [N_SLOTS-1:0]      coords;
  } job_t;

  // Queue status seen by the parser
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Lowercase hex character to value, anything else is zero
  function automatic logic [3:0] nibble_of(input logic [BYTE_W-1:0] c);
    logic [3:0] n;
    n = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) n = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) n = 4'(c - 8'h57);
    return n;
  endfunction

  // Value to lowercase hex character
  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n);
    logic [BYTE_W-1:0] c;
    if (n < 4'd10) c = 8'h30 + {4'h0, n};
    else c = 8'h57 + {4'h0, n};
    return c;
  endfunction

endpackage

@@ rtl/hppd_if.sv @@
// Channel interfaces of the decoder: received bytes in, entity updates out.
// Depends on hppd_pkg.
interface hppd_rx_if;
  logic                         valid;
  logic                         ready;
  logic [hppd_pkg::BYTE_W-1:0]  rx_byte;
  logic                         start_of_packet;

  modport source (output valid, rx_byte, start_of_packet, input ready);
  modport sink (input valid, rx_byte, start_of_packet, output ready);
endinterface

interface hppd_upd_if;
  logic                         valid;
  logic                         ready;
  logic [hppd_pkg::ENT_W-1:0]   entity;
  hppd_pkg::coord_t             pos_x;
  hppd_pkg::coord_t             pos_y;
  hppd_pkg::coord_t             prev_x;
  hppd_pkg::coord_t             prev_y;
  logic                         last_update;

  modport source (output valid, entity, pos_x, pos_y, prev_x, prev_y, last_update,
                  input ready);
  modport sink (input valid, entity, pos_x, pos_y, prev_x, prev_y, last_update,
                output ready);
endinterface

@@ rtl/hppd_front.sv @@
// Packet parser: tracks byte position, assembles coordinates, checks the checksum.
// Depends on hppd_pkg and hppd_rx_if; pushes checked packets to hppd_queue.
module hppd_front (
  input  logic              clk,
  input  logic              rst,
  hppd_rx_if.sink           rx,
  input  hppd_pkg::q_stat_t qstat,
  output logic              push,
  output hppd_pkg::job_t    job
);

  hppd_pkg::kind_t                          kind;
  logic [hppd_pkg::POS_W-1:0]               pos;
  logic [hppd_pkg::BYTE_W-1:0]              xor_acc;
  logic [hppd_pkg::BYTE_W-1:0]              cks_hi;
  hppd_pkg::coord_t [hppd_pkg::N_SLOTS-1:0] pending;
  logic [hppd_pkg::DIGIT_W-1:0]             digit;
  logic [hppd_pkg::SLOT_W-1:0]              slot;

  logic                        acc;
  logic [hppd_pkg::POS_W-1:0]  end_pos;
  logic                        in_payload;
  logic                        at_cks_hi;
  logic                        at_cks_lo;
  logic                        cks_match;

  // A word is taken whenever the queue has room
  assign rx.ready = !qstat.full;
  assign acc      = rx.valid && rx.ready;

  // Region decode of the current byte
  assign end_pos    = (kind == hppd_pkg::KIND_P) ? hppd_pkg::POS_W'(hppd_pkg::P_END)
                                                 : hppd_pkg::POS_W'(hppd_pkg::A_END);
  assign in_payload = (pos >= hppd_pkg::POS_W'(hppd_pkg::HEADER_BYTES)) && (pos < end_pos);
  assign at_cks_hi  = (pos == end_pos);
  assign at_cks_lo  = (pos == end_pos + hppd_pkg::POS_W'(1));
  assign cks_match  = (cks_hi == hppd_pkg::hex_char(xor_acc[7:4])) &&
                      (rx.rx_byte == hppd_pkg::hex_char(xor_acc[3:0]));

  // Hand over on a good checksum
  assign push = acc && !rx.start_of_packet && (kind != hppd_pkg::KIND_NONE) &&
                at_cks_lo && cks_match;
  assign job.is_a   = (kind == hppd_pkg::KIND_A);
  assign job.coords = pending;

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      kind    <= hppd_pkg::KIND_NONE;
      pos     <= '0;
      xor_acc <= '0;
      cks_hi  <= '0;
      digit   <= '0;
      slot    <= '0;
    end else if (acc) begin
      if (rx.start_of_packet) begin
        if (rx.rx_byte == hppd_pkg::CHAR_P) kind <= hppd_pkg::KIND_P;
        else if (rx.rx_byte == hppd_pkg::CHAR_A) kind <= hppd_pkg::KIND_A;
        else kind <= hppd_pkg::KIND_NONE;
        pos     <= hppd_pkg::POS_W'(1);
        xor_acc <= '0;
        cks_hi  <= '0;
        digit   <= '0;
        slot    <= '0;
      end else if (kind != hppd_pkg::KIND_NONE) begin
        if (in_payload) begin
          xor_acc <= xor_acc ^ rx.rx_byte;
          if (digit == hppd_pkg::DIGIT_W'(hppd_pkg::COORD_DIGITS - 1)) begin
            digit <= '0;
            slot  <= slot + hppd_pkg::SLOT_W'(1);
          end else begin
            digit <= digit + hppd_pkg::DIGIT_W'(1);
          end
        end else if (at_cks_hi) begin
          cks_hi <= rx.rx_byte;
        end else if (at_cks_lo) begin
          kind <= hppd_pkg::KIND_NONE;
        end
        pos <= (pos < hppd_pkg::POS_W'(hppd_pkg::POS_MAX)) ? pos + hppd_pkg::POS_W'(1)
                                                           : pos;
      end
    end
  end

  // Coordinate assembly, cleared at each packet start
  always_ff @(posedge clk) begin
    if (acc) begin
      if (rx.start_of_packet) begin
        pending <= '0;
      end else if (kind != hppd_pkg::KIND_NONE && in_payload) begin
        pending[slot] <= {pending[slot][hppd_pkg::COORD_W-5:0],
                          hppd_pkg::nibble_of(rx.rx_byte)};
      end
    end
  end

endmodule

@@ rtl/hppd_queue.sv @@
// Two-entry queue of checked packets between parser and update sequencer.
// Depends on hppd_pkg.
module hppd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hppd_pkg::job_t    wr_job,
  input  logic              pop,
  output hppd_pkg::job_t    head,
  output hppd_pkg::q_stat_t qstat
);

  hppd_pkg::job_t                mem [hppd_pkg::QUEUE_DEPTH];
  logic [hppd_pkg::QPTR_W-1:0]   wr_ptr;
  logic [hppd_pkg::QPTR_W-1:0]   rd_ptr;
  logic [hppd_pkg::QCNT_W-1:0]   count;

  assign head        = mem[rd_ptr];
  assign qstat.full  = (count == hppd_pkg::QCNT_W'(hppd_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + hppd_pkg::QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + hppd_pkg::QPTR_W'(1);
      if (push && !pop) count <= count + hppd_pkg::QCNT_W'(1);
      else if (pop && !push) count <= count - hppd_pkg::QCNT_W'(1);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_job;
  end

endmodule

@@ rtl/hppd_back.sv @@
// Update sequencer: walks the entities of a checked packet, keeps the position table.
// Depends on hppd_pkg, hppd_upd_if and the assertion macros header.
`include "hex_position_packet_decoder_unit_macros.svh"

module hppd_back (
  input  logic              clk,
  input  logic              rst,
  input  hppd_pkg::job_t    head,
  input  hppd_pkg::q_stat_t qstat,
  output logic              pop,
  hppd_upd_if.source        upd
);

  logic [hppd_pkg::STEP_W-1:0]  step;
  hppd_pkg::coord_t             tab_x [hppd_pkg::N_ENT];
  hppd_pkg::coord_t             tab_y [hppd_pkg::N_ENT];

  logic [hppd_pkg::ENT_W-1:0]   ent;
  logic [hppd_pkg::SLOT_W-1:0]  slot_x;
  logic                         last;
  logic                         load;
  hppd_pkg::coord_t             nx;
  hppd_pkg::coord_t             ny;

  // Entity order: P gives ball, cars 1 to 3; A gives start then goal
  always_comb begin
    if (head.is_a) begin
      ent    = (step == '0) ? hppd_pkg::ENT_START : hppd_pkg::ENT_GOAL;
      slot_x = (step == '0) ? hppd_pkg::SLOT_W'(2) : '0;
      last   = (step == hppd_pkg::STEP_W'(1));
    end else begin
      ent    = hppd_pkg::ENT_BALL + hppd_pkg::ENT_W'(step);
      slot_x = {step, 1'b0};
      last   = (step == hppd_pkg::STEP_W'(3));
    end
  end

  assign nx   = head.coords[slot_x];
  assign ny   = head.coords[slot_x + hppd_pkg::SLOT_W'(1)];
  assign load = !qstat.empty && (!upd.valid || upd.ready);
  assign pop  = load && last;

  // Output word register and entity step
  always_ff @(posedge clk) begin
    if (rst) begin
      upd.valid <= 1'b0;
      step      <= '0;
    end else begin
      if (load) begin
        upd.valid <= 1'b1;
        step      <= last ? '0 : step + hppd_pkg::STEP_W'(1);
      end else if (upd.ready) begin
        upd.valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      upd.entity      <= ent;
      upd.pos_x       <= nx;
      upd.pos_y       <= ny;
      upd.prev_x      <= tab_x[ent];
      upd.prev_y      <= tab_y[ent];
      upd.last_update <= last;
    end
  end

  // Position table, previous position comes from the current entry
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hppd_pkg::N_ENT; i++) begin
        tab_x[i] <= '0;
        tab_y[i] <= '0;
      end
    end else if (load) begin
      tab_x[ent] <= nx;
      tab_y[ent] <= ny;
    end
  end

  `HPPD_ASSERT_IMP(a_last_entity, upd.valid && upd.last_update, upd.entity == hppd_pkg::ENT_CAR3 || upd.entity == hppd_pkg::ENT_GOAL, "last update on wrong entity")
  `HPPD_ASSERT_IMP(a_step_head, step != '0, !qstat.empty, "packet left queue mid sequence")
  `HPPD_ASSERT_IMP(a_a_steps, !qstat.empty && head.is_a, step <= hppd_pkg::STEP_W'(1), "A packet step overrun")
  `HPPD_ASSERT_NXT(a_load_shows, load, upd.valid, "loaded update not presented")

endmodule

@@ rtl/hex_position_packet_decoder_unit.sv @@
// Top level of the hex position packet decoder: parser, packet queue, update sequencer.
// Depends on hppd_pkg, hppd_if, hppd_front, hppd_queue and hppd_back.
//
//  channel | role  | word
//  rx      | sink  | rx_byte, start_of_packet
//  upd     | source| entity, pos_x, pos_y, prev_x, prev_y, last_update
//
// One received byte is taken per cycle; rx.ready drops only while both queue entries
// hold checked packets. A checked packet passes the queue and then the upd output register;
// it gives one update per cycle while upd is ready (4 for P, 2 for A), from the sequencer's table port.
// Synchronous reset clears parser, queue and the entity position table.
// Stalls on upd hold the output register; rx keeps running until the queue fills.
module hex_position_packet_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  hppd_rx_if.sink     rx,
  hppd_upd_if.source  upd
);

  logic               push;
  logic               pop;
  hppd_pkg::job_t     wr_job;
  hppd_pkg::job_t     head;
  hppd_pkg::q_stat_t  qstat;

  hppd_front u_front (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .qstat (qstat),
    .push  (push),
    .job   (wr_job)
  );

  hppd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .head   (head),
    .qstat  (qstat)
  );

  hppd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .upd   (upd)
  );

endmodule
